/* src/msdf_pkg.sv */
`default_nettype none
package msdf_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int XW = 6;
  localparam int YW = 6;
  localparam int AddrW = XW + YW;
  localparam int D2W = 14;   // squared distance up to 2*63*63
  localparam int RootW = 23; // root of d2 * 2^32, Q16
  localparam int QW = 32;    // quotient width

  // register indexes
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegSpread = 2'd2;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // base 127.5 in Q16
  localparam logic [QW-1:0] Base = 32'd8355840;

  typedef struct packed {
    logic         start;
    logic [D2W-1:0] d2;
    logic [7:0]   spread;
  } calc_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] q;
  } calc_rsp_t;
endpackage
`default_nettype wire

/* src/msdf_calc.sv */
`default_nettype none
// shared shift-subtract unit: root then divide, one bit per cycle
module msdf_calc (
  input  wire                 clk,
  input  wire                 rst_n,
  input  msdf_pkg::calc_req_t req,
  output msdf_pkg::calc_rsp_t rsp
);
  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_ROOT = 3'b010,
    C_DIV  = 3'b100
  } cstate_t;

  cstate_t        st_r, st_nxt;
  logic [47:0]    rad_r, rad_nxt;   // radicand d2 << 32, shifted out 2 bits/step
  logic [25:0]    rem_r, rem_nxt;   // root remainder
  logic [msdf_pkg::RootW:0] root_r, root_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic [8:0]     div_r, div_nxt;   // 2*spread
  logic [31:0]    num_r, num_nxt;   // 255*root, shifted out
  logic [9:0]     drem_r, drem_nxt;
  logic [msdf_pkg::QW-1:0] q_r, q_nxt;
  logic           done_r, done_nxt;
  logic [25:0]    trial;
  logic [9:0]     dtrial;

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

  always_comb begin
    st_nxt = st_r; rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r;
    cnt_nxt = cnt_r; div_nxt = div_r; num_nxt = num_r; drem_nxt = drem_r;
    q_nxt = q_r; done_nxt = 1'b0;
    trial  = {rem_r[23:0], rad_r[47:46]} - {root_r[msdf_pkg::RootW-1:0], 2'b01};
    dtrial = {drem_r[8:0], num_r[31]} - {1'b0, div_r};
    case (st_r)
      C_IDLE: begin
        if (req.start) begin
          rad_nxt  = {2'b0, req.d2, 32'd0};
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = 6'd24;
          div_nxt  = {req.spread, 1'b0};
          st_nxt   = C_ROOT;
        end
      end
      C_ROOT: begin
        rad_nxt = {rad_r[45:0], 2'b00};
        if (!trial[25] &&
            ({rem_r[23:0], rad_r[47:46]} >= {root_r[msdf_pkg::RootW-1:0], 2'b01})) begin
          rem_nxt  = trial;
          root_nxt = {root_r[msdf_pkg::RootW-1:0], 1'b1};
        end else begin
          rem_nxt  = {rem_r[23:0], rad_r[47:46]};
          root_nxt = {root_r[msdf_pkg::RootW-1:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          num_nxt  = 32'(({8'd0, root_nxt} << 8) - {8'd0, root_nxt});
          drem_nxt = '0;
          q_nxt    = '0;
          cnt_nxt  = 6'd32;
          st_nxt   = C_DIV;
        end
      end
      C_DIV: begin
        num_nxt = {num_r[30:0], 1'b0};
        if ({drem_r[8:0], num_r[31]} >= {1'b0, div_r}) begin
          drem_nxt = dtrial;
          q_nxt    = {q_r[msdf_pkg::QW-2:0], 1'b1};
        end else begin
          drem_nxt = {drem_r[8:0], num_r[31]};
          q_nxt    = {q_r[msdf_pkg::QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_nxt = 1'b1;
          st_nxt   = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r <= rad_nxt; rem_r <= rem_nxt; root_r <= root_nxt;
    div_r <= div_nxt; num_r <= num_nxt; drem_r <= drem_nxt; q_r <= q_nxt;
  end
endmodule
`default_nettype wire

/* src/mask_signed_distance_field_core.sv */
`default_nettype none
// channel | dir | handshake         | payload
// in      | in  | tvalid/tready     | tdata: operation, pixel_x, pixel_y, mask_value
// out     | out | tvalid/tready     | tdata: out_x, out_y, distance_value
// cfg     | in  | valid/ready       | index 2b, data 8b
// a write is taken back to back; a query reads its own pixel, then
// scans one pixel per cycle from the one-port mask ram, then, if a pixel of the
// other class is found, the shared root/divide unit works out the distance; a
// query with a zero size or spread, or outside the image, skips both.
// reset is synchronous, active low; the mask ram is not cleared.
// the block takes no request while a result waits on out_tready.
module mask_signed_distance_field_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // operation, pixel_x, pixel_y, mask_value, pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // out_x, out_y, distance_value, pad
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SELF = 6'b000010,
    S_SCAN = 6'b000100,
    S_CALC = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t st_r;
  logic [6:0] w_r, h_r;
  logic [7:0] spread_r;
  logic [5:0] qx_r, qy_r, sx_r, sy_r;
  logic       self_r, found_r, rd_v_r, end_r;
  logic [5:0] rdx_r, rdy_r;
  logic [msdf_pkg::D2W-1:0] best_r;
  logic [7:0] res_r;
  logic       mem [msdf_pkg::MaxWidth*msdf_pkg::MaxHeight];
  logic       rdata_r;
  logic [6:0] we, he;
  logic [5:0] dx, dy;
  logic [msdf_pkg::D2W-1:0] d2;
  logic [msdf_pkg::QW-1:0]  v;
  msdf_pkg::calc_req_t creq;
  msdf_pkg::calc_rsp_t crsp;

  assign cfg_ready  = (st_r == S_IDLE);
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {4'd0, res_r, qy_r, qx_r};
  assign we = (w_r > 7'(msdf_pkg::MaxWidth)) ? 7'(msdf_pkg::MaxWidth) : w_r;
  assign he = (h_r > 7'(msdf_pkg::MaxHeight)) ? 7'(msdf_pkg::MaxHeight) : h_r;

  // distance of the pixel read last cycle
  assign dx = (rdx_r > qx_r) ? rdx_r - qx_r : qx_r - rdx_r;
  assign dy = (rdy_r > qy_r) ? rdy_r - qy_r : qy_r - rdy_r;
  assign d2 = msdf_pkg::D2W'({8'd0, dx} * {8'd0, dx}) +
              msdf_pkg::D2W'({8'd0, dy} * {8'd0, dy});

  assign creq.start  = (st_r == S_CALC);
  assign creq.d2     = best_r;
  assign creq.spread = spread_r;

  msdf_calc u_calc (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  assign v = self_r ? msdf_pkg::Base + crsp.q : msdf_pkg::Base - crsp.q;

  // mask ram
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && in_tdata[0] == msdf_pkg::OpWrite)
      mem[{in_tdata[12:7], in_tdata[6:1]}] <= (in_tdata[20:13] > 8'd127);
    rdata_r <= (st_r == S_IDLE) ? mem[{in_tdata[12:7], in_tdata[6:1]}] :
                                  mem[{sy_r, sx_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; w_r <= 7'd64; h_r <= 7'd64; spread_r <= 8'd8;
      rd_v_r <= 1'b0; found_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == msdf_pkg::RegWidth)  w_r <= {cfg_data[6:0]};
            if (cfg_index == msdf_pkg::RegHeight) h_r <= {cfg_data[6:0]};
            if (cfg_index == msdf_pkg::RegSpread) spread_r <= cfg_data;
          end
          if (in_tvalid && in_tdata[0] == msdf_pkg::OpQuery) begin
            qx_r <= in_tdata[6:1]; qy_r <= in_tdata[12:7];
            sx_r <= '0; sy_r <= '0; found_r <= 1'b0; end_r <= 1'b0;
            if (we == 0 || he == 0 || spread_r == 0 ||
                {1'b0, in_tdata[6:1]} >= we || {1'b0, in_tdata[12:7]} >= he) begin
              res_r <= 8'd0; st_r <= S_OUT;
            end else st_r <= S_SELF;
          end
        end
        S_SELF: begin
          self_r <= rdata_r;
          rd_v_r <= 1'b0;
          st_r   <= S_SCAN;
        end
        S_SCAN: begin
          // issue one read per cycle up to the last pixel, compare the previous one
          rd_v_r <= !end_r;
          if (!end_r) begin
            rdx_r <= sx_r; rdy_r <= sy_r;
            if ({1'b0, sx_r} == we - 7'd1) begin
              sx_r <= '0; sy_r <= sy_r + 6'd1;
              if ({1'b0, sy_r} == he - 7'd1) end_r <= 1'b1;
            end else sx_r <= sx_r + 6'd1;
          end
          if (rd_v_r && rdata_r != self_r && (!found_r || d2 < best_r)) begin
            best_r <= d2; found_r <= 1'b1;
          end
          if (end_r && !rd_v_r) begin
            if (found_r) st_r <= S_CALC;
            else begin
              res_r <= self_r ? 8'd255 : 8'd0; st_r <= S_OUT;
            end
          end
        end
        S_CALC: st_r <= S_WAIT;
        S_WAIT: begin
          if (crsp.done) begin
            if (self_r) res_r <= (v[31:16] >= 16'd255) ? 8'd255 : v[23:16];
            else res_r <= (crsp.q >= msdf_pkg::Base) ? 8'd0 : v[23:16];
            st_r <= S_OUT;
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sim/mask_signed_distance_field_core_test.sv */
`default_nettype none
module mask_signed_distance_field_core_test;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int NoTyped = -1;
  localparam int FillW = 8;
  localparam int FillH = 8;
  localparam int HoldLen = 3000;

  typedef struct {
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] v;
  } sdf_result_t;

  // one directed row: a register write or a request, typed result or NoTyped
  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    int         data;
    logic       op;
    int         x;
    int         y;
    int         m;
    int         typed;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // operation, pixel_x, pixel_y, mask_value, pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // out_x, out_y, distance_value, pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // predictor copy of the block
  bit          inside_bits [msdf_pkg::MaxWidth*msdf_pkg::MaxHeight];
  int          img_w = 64;
  int          img_h = 64;
  int          spread = 8;
  sdf_result_t result_q [$];

  int sender_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int hold_starts = 0;
  int hold_seen = 0;
  bit failed = 1'b0;

  mask_signed_distance_field_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // floored integer root of a 64-bit value
  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // distance byte for one queried pixel
  function automatic logic [7:0] sdf_value(int x, int y);
    int w, h, dx, dy;
    bit self_in, found;
    longint unsigned best, d2, dq, q, v, base;
    w = img_w > msdf_pkg::MaxWidth ? msdf_pkg::MaxWidth : img_w;
    h = img_h > msdf_pkg::MaxHeight ? msdf_pkg::MaxHeight : img_h;
    base = 64'd255 << 15;
    found = 1'b0;
    best = 0;
    if (w == 0 || h == 0 || spread == 0) return 8'd0;
    if (x >= w || y >= h) return 8'd0;
    self_in = inside_bits[y*msdf_pkg::MaxWidth + x];
    for (int ny = 0; ny < h; ny++) begin
      for (int nx = 0; nx < w; nx++) begin
        if (inside_bits[ny*msdf_pkg::MaxWidth + nx] != self_in) begin
          dx = nx - x;
          dy = ny - y;
          d2 = dx*dx + dy*dy;
          if (!found || d2 < best) begin
            best = d2;
            found = 1'b1;
          end
        end
      end
    end
    if (!found) return self_in ? 8'd255 : 8'd0;
    dq = isqrt64(best << 32);
    q = (255 * dq) / (2 * spread);
    if (self_in) begin
      v = (base + q) >> 16;
      return v >= 255 ? 8'd255 : v[7:0];
    end
    if (q >= base) return 8'd0;
    v = (base - q) >> 16;
    return v[7:0];
  endfunction

  // send one request, track the store and the expected result
  task automatic send_req(input logic op, input int x, input int y, input int m,
                          input int typed);
    logic [5:0] px, py;
    logic [7:0] mv;
    px = x[5:0];
    py = y[5:0];
    mv = m[7:0];
    while ($urandom_range(99) < sender_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, mv, py, px, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == msdf_pkg::OpWrite) begin
      inside_bits[py*msdf_pkg::MaxWidth + px] = mv > 127;
    end else begin
      result_q.push_back('{px, py,
                           typed >= 0 ? typed[7:0] : sdf_value(px, py)});
    end
  endtask

  // register write once the block has drained
  task automatic write_reg(input logic [1:0] idx, input int data);
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[7:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      msdf_pkg::RegWidth:  img_w = data & 8'h7f;
      msdf_pkg::RegHeight: img_h = data & 8'h7f;
      msdf_pkg::RegSpread: spread = data & 8'hff;
      default: ;
    endcase
  endtask

  // result side: check accepted results, then pick next ready
  always @(posedge clk) begin
    sdf_result_t want;
    if (out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result: actual x=%0d y=%0d v=%0d", $time,
                 out_tdata[5:0], out_tdata[11:6], out_tdata[19:12]);
        failed = 1'b1;
      end else begin
        want = result_q.pop_front();
        if (out_tdata[5:0] !== want.x) begin
          $display("%0t out_x: expected %0d actual %0d", $time, want.x, out_tdata[5:0]);
          failed = 1'b1;
        end
        if (out_tdata[11:6] !== want.y) begin
          $display("%0t out_y: expected %0d actual %0d", $time, want.y, out_tdata[11:6]);
          failed = 1'b1;
        end
        if (out_tdata[19:12] !== want.v) begin
          $display("%0t distance_value at (%0d,%0d): expected %0d actual %0d", $time,
                   want.x, want.y, want.v, out_tdata[19:12]);
          failed = 1'b1;
        end
      end
    end
    if (hold_starts != hold_seen) begin
      hold_seen <= hold_starts;
      hold_cycles <= HoldLen;
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    plan_row_t plan [] = '{
      '{1, msdf_pkg::RegWidth, 0, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 5, 5, 0, 0},
      '{1, msdf_pkg::RegWidth, 127, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{1, msdf_pkg::RegSpread, 0, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 32, 32, 0, 0},
      '{1, msdf_pkg::RegHeight, 0, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{1, msdf_pkg::RegSpread, 255, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 10, 3, 0, 0},
      '{1, msdf_pkg::RegHeight, 2, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 1, 5, 0, 0},
      '{1, msdf_pkg::RegWidth, 8, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{1, msdf_pkg::RegHeight, 8, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 4, 4, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 0, 0, 0, NoTyped},
      '{1, RegUnused, 55, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{1, msdf_pkg::RegSpread, 1, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 3, 7, 0, NoTyped},
      '{1, msdf_pkg::RegWidth, 4, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{1, msdf_pkg::RegHeight, 4, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 10, 2, 0, 0},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 2, 10, 0, 0},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpWrite, 0, 0, 127, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpWrite, 1, 0, 128, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 1, 0, 0, NoTyped},
      '{1, msdf_pkg::RegWidth, 1, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{1, msdf_pkg::RegHeight, 1, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 0, 0, 0, 0},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpWrite, 0, 0, 255, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 0, 0, 0, 255},
      '{1, msdf_pkg::RegHeight, 0, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 0, 0, 0, 0},
      '{1, msdf_pkg::RegWidth, 8, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{1, msdf_pkg::RegHeight, 8, msdf_pkg::OpWrite, 0, 0, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpWrite, 7, 7, 0, NoTyped},
      '{0, msdf_pkg::RegWidth, 0, msdf_pkg::OpQuery, 7, 7, 0, NoTyped}
    };
    int pct_send [4] = '{0, 76, 0, 18};
    int pct_stall [4] = '{0, 0, 76, 18};
    int w, h, x, y, m;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill the store area in use: a disc of inside pixels, random coverage per class
    for (int py = 0; py < FillH; py++) begin
      for (int px = 0; px < FillW; px++) begin
        m = ((px-4)*(px-4) + (py-4)*(py-4) < 9) ?
            $urandom_range(255, 128) : $urandom_range(127, 0);
        send_req(msdf_pkg::OpWrite, px, py, m, NoTyped);
      end
    end

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_req(plan[i].op, plan[i].x, plan[i].y, plan[i].m, plan[i].typed);
    end

    // random phases, one per idling mode, fresh sizes each
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(msdf_pkg::RegWidth, $urandom_range(FillW, 1));
      write_reg(msdf_pkg::RegHeight, $urandom_range(FillH, 1));
      write_reg(msdf_pkg::RegSpread, $urandom_range(4) == 0 ? 255 : $urandom_range(40, 1));
      sender_pct = pct_send[ph];
      stall_pct = pct_stall[ph];
      w = img_w > msdf_pkg::MaxWidth ? msdf_pkg::MaxWidth : img_w;
      h = img_h > msdf_pkg::MaxHeight ? msdf_pkg::MaxHeight : img_h;
      for (int k = 0; k < 15; k++) begin
        if (ph == 0 && k == 5) hold_starts = hold_starts + 1;
        // mostly inside the image in use, some anywhere
        if ($urandom_range(9) < 8) begin
          x = $urandom_range(w - 1);
          y = $urandom_range(h - 1);
        end else begin
          x = $urandom_range(63);
          y = $urandom_range(63);
        end
        if ($urandom_range(9) < 6) begin
          send_req(msdf_pkg::OpQuery, x, y, $urandom_range(255), NoTyped);
        end else begin
          send_req(msdf_pkg::OpWrite, x, y, $urandom_range(255), NoTyped);
        end
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
src/msdf_pkg.sv
src/msdf_calc.sv
src/mask_signed_distance_field_core.sv
sim/mask_signed_distance_field_core_test.sv
